// ===== design/m6502_pkg.sv =====
package m6502_pkg;

	// Default size of the byte memory.
	localparam int unsigned M6502_MEM_BYTES = 65536;

	// Opcodes the core executes.
	localparam logic [7:0] OP_LDA_IMM = 8'hA9;
	localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
	localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
	localparam logic [7:0] OP_JSR     = 8'h20;

	localparam logic [15:0] PC_RESET  = 16'hFFFC;
	localparam logic [7:0]  SP_RESET  = 8'hFF;
	localparam logic [7:0]  SIGN_BIT  = 8'b1000_0000;

	// Cycle counts charged per instruction class.
	localparam logic [2:0] CYC_WRITE   = 3'd0;
	localparam logic [2:0] CYC_UNKNOWN = 3'd1;
	localparam logic [2:0] CYC_LDA_IMM = 3'd2;
	localparam logic [2:0] CYC_LDA_ZP  = 3'd3;
	localparam logic [2:0] CYC_LDA_ZPX = 3'd4;
	localparam logic [2:0] CYC_JSR     = 3'd6;

	typedef logic [4:0] upc_t;

	// Microprogram step addresses.
	localparam upc_t UPC_E0 = 5'd0;   // opcode fetch
	localparam upc_t UPC_E1 = 5'd1;   // opcode dispatch
	localparam upc_t UPC_U0 = 5'd2;   // unknown opcode
	localparam upc_t UPC_I0 = 5'd3;
	localparam upc_t UPC_I1 = 5'd4;
	localparam upc_t UPC_Z0 = 5'd5;
	localparam upc_t UPC_Z1 = 5'd6;
	localparam upc_t UPC_Z2 = 5'd7;
	localparam upc_t UPC_X0 = 5'd8;
	localparam upc_t UPC_X1 = 5'd9;
	localparam upc_t UPC_X2 = 5'd10;
	localparam upc_t UPC_J0 = 5'd11;
	localparam upc_t UPC_J1 = 5'd12;
	localparam upc_t UPC_J2 = 5'd13;
	localparam upc_t UPC_J3 = 5'd14;
	localparam upc_t UPC_J4 = 5'd15;
	localparam upc_t UPC_W0 = 5'd16;
	localparam upc_t UPC_W1 = 5'd17;
	localparam upc_t UPC_W2 = 5'd18;

	typedef enum logic [1:0] {
		ADDR_PC,
		ADDR_ZP,
		ADDR_STACK,
		ADDR_RED
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_IN,
		WD_RET_HI,
		WD_RET_LO
	} wd_sel_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_DISPATCH,
		SEQ_DONE
	} seq_t;

	typedef enum logic {
		RED_IN,
		RED_TARGET
	} red_sel_t;

	typedef struct packed {
		addr_sel_t  addr_sel;
		logic       mem_rd;
		logic       mem_wr;
		wd_sel_t    wd_sel;
		logic       pc_inc;
		logic       sp_dec;
		logic       ld_lo;
		logic       ld_acc;
		logic       zp_x;
		logic       red_start;
		red_sel_t   red_sel;
		logic       pc_jump;
		logic       unknown;
		logic [2:0] cycles;
		seq_t       seq;
		upc_t       next;
	} ucw_t;

	// Microcode ROM. A read issued in one step returns its byte in the next.
	function automatic ucw_t ucode(input upc_t upc);
		ucw_t w;
		w = '0;
		case (upc)
			UPC_E0: begin
				w.addr_sel = ADDR_PC;
				w.mem_rd   = 1'b1;
				w.pc_inc   = 1'b1;
				w.next     = UPC_E1;
			end
			UPC_E1: begin
				w.seq = SEQ_DISPATCH;
			end
			UPC_U0: begin
				w.unknown = 1'b1;
				w.cycles  = CYC_UNKNOWN;
				w.seq     = SEQ_DONE;
			end
			UPC_I0: begin
				w.addr_sel = ADDR_PC;
				w.mem_rd   = 1'b1;
				w.pc_inc   = 1'b1;
				w.next     = UPC_I1;
			end
			UPC_I1: begin
				w.ld_acc = 1'b1;
				w.cycles = CYC_LDA_IMM;
				w.seq    = SEQ_DONE;
			end
			UPC_Z0: begin
				w.addr_sel = ADDR_PC;
				w.mem_rd   = 1'b1;
				w.pc_inc   = 1'b1;
				w.next     = UPC_Z1;
			end
			UPC_Z1: begin
				w.addr_sel = ADDR_ZP;
				w.mem_rd   = 1'b1;
				w.next     = UPC_Z2;
			end
			UPC_Z2: begin
				w.ld_acc = 1'b1;
				w.cycles = CYC_LDA_ZP;
				w.seq    = SEQ_DONE;
			end
			UPC_X0: begin
				w.addr_sel = ADDR_PC;
				w.mem_rd   = 1'b1;
				w.pc_inc   = 1'b1;
				w.next     = UPC_X1;
			end
			UPC_X1: begin
				w.addr_sel = ADDR_ZP;
				w.zp_x     = 1'b1;
				w.mem_rd   = 1'b1;
				w.next     = UPC_X2;
			end
			UPC_X2: begin
				w.ld_acc = 1'b1;
				w.cycles = CYC_LDA_ZPX;
				w.seq    = SEQ_DONE;
			end
			UPC_J0: begin
				w.addr_sel = ADDR_PC;
				w.mem_rd   = 1'b1;
				w.pc_inc   = 1'b1;
				w.next     = UPC_J1;
			end
			UPC_J1: begin
				w.ld_lo    = 1'b1;
				w.addr_sel = ADDR_PC;
				w.mem_rd   = 1'b1;
				w.pc_inc   = 1'b1;
				w.next     = UPC_J2;
			end
			UPC_J2: begin
				w.red_start = 1'b1;
				w.red_sel   = RED_TARGET;
				w.addr_sel  = ADDR_STACK;
				w.mem_wr    = 1'b1;
				w.wd_sel    = WD_RET_HI;
				w.sp_dec    = 1'b1;
				w.next      = UPC_J3;
			end
			UPC_J3: begin
				w.addr_sel = ADDR_STACK;
				w.mem_wr   = 1'b1;
				w.wd_sel   = WD_RET_LO;
				w.sp_dec   = 1'b1;
				w.next     = UPC_J4;
			end
			UPC_J4: begin
				w.pc_jump = 1'b1;
				w.cycles  = CYC_JSR;
				w.seq     = SEQ_DONE;
			end
			UPC_W0: begin
				w.red_start = 1'b1;
				w.red_sel   = RED_IN;
				w.next      = UPC_W1;
			end
			UPC_W1: begin
				w.next = UPC_W2;
			end
			UPC_W2: begin
				w.addr_sel = ADDR_RED;
				w.mem_wr   = 1'b1;
				w.wd_sel   = WD_IN;
				w.cycles   = CYC_WRITE;
				w.seq      = SEQ_DONE;
			end
			default: begin
				w.cycles = CYC_UNKNOWN;
				w.seq    = SEQ_DONE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== design/m6502_if.sv =====
interface m6502_item_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] mem_address;
	logic [7:0]  mem_data;

	modport source (output valid, action, mem_address, mem_data, input ready);
	modport sink (input valid, action, mem_address, mem_data, output ready);
endinterface

interface m6502_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  accumulator;
	logic [15:0] program_counter;
	logic [7:0]  stack_pointer;
	logic        zero_flag;
	logic        negative_flag;
	logic        unknown_opcode;
	logic [2:0]  cycles_used;

	modport source (
		output valid, accumulator, program_counter, stack_pointer, zero_flag,
		       negative_flag, unknown_opcode, cycles_used,
		input  ready
	);
	modport sink (
		input  valid, accumulator, program_counter, stack_pointer, zero_flag,
		       negative_flag, unknown_opcode, cycles_used,
		output ready
	);
endinterface

// ===== design/m6502_addr_mod.sv =====
// Two-stage reduction of a 16-bit address modulo the memory size.
// Stage one estimates the quotient by a reciprocal multiply; stage two
// subtracts quotient times size and corrects by one size at most.
module m6502_addr_mod import m6502_pkg::*; #(
	parameter int unsigned MEM_BYTES = M6502_MEM_BYTES,
	localparam int unsigned AW = $clog2(MEM_BYTES)
) (
	input  logic          clk,
	input  logic          load,
	input  logic [15:0]   addr,
	output logic [AW-1:0] rem
);

	localparam int unsigned RECIP = 32'h0100_0000 / MEM_BYTES;
	localparam logic [16:0] RECIP_W = 17'(RECIP);
	localparam logic [17:0] SIZE_W = 18'(MEM_BYTES);

	logic [15:0]   addr_s1;
	logic [7:0]    quot_s1;
	logic [AW-1:0] rem_s2;
	logic [31:0]   prod;
	logic [24:0]   qm;
	logic [17:0]   diff;
	logic [17:0]   fixed;

	assign prod  = 32'(addr) * 32'(RECIP_W);
	assign qm    = 25'(quot_s1) * 25'(SIZE_W);
	assign diff  = 18'(25'(addr_s1) - qm);
	assign fixed = (diff >= SIZE_W) ? (diff - SIZE_W) : diff;

	always_ff @(posedge clk) begin
		if (load) begin
			addr_s1 <= addr;
			quot_s1 <= prod[31:24];
		end
		rem_s2 <= fixed[AW-1:0];
	end

	assign rem = rem_s2;

endmodule

// ===== design/mini_6502_load_jsr_core.sv =====
// A small 6502-style core with its own byte memory.
// Each transaction on the item channel either stores one byte in memory
// (action 0, for loading a program) or executes one instruction at PC
// (action 1): LDA immediate, LDA zero page, LDA zero page,X and JSR. Any
// other opcode consumes one byte and reports unknown_opcode. Every item
// produces exactly one transaction on the result channel with A, PC, SP,
// Z, N and the cycle count charged. X is written through the config port.
// A microcoded sequencer steps a single-port memory: one access per step.
// Each item runs its own microprogram steps from acceptance to a registered
// result, and the next item can be taken in the cycle after the result is
// registered, so the core works on one item at a time. The memory port
// sets the number of steps: every operand byte and each stack push is a
// step of its own, and writes and JSR targets wait for the registered
// address reduction modulo the memory size.
// After reset the core clears the memory one byte per cycle, all MEM_BYTES
// bytes, with item ready held low. If the receiver stalls, the result
// stays in the output register; the core may run the next item, but waits
// in its final step until the register is free.
module mini_6502_load_jsr_core import m6502_pkg::*; #(
	parameter int unsigned MEM_BYTES = M6502_MEM_BYTES
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	m6502_item_if.sink     item,
	m6502_result_if.source result
);

	localparam int unsigned AW = $clog2(MEM_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);
	localparam logic [AW-1:0] PCM_RESET = AW'(int'(PC_RESET) % MEM_BYTES);
	localparam logic [16:0] SIZE_W = 17'(MEM_BYTES);

	// Byte memory; cleared by a sweep after reset.
	logic [7:0] mem [MEM_BYTES];
	logic [7:0] rdata_q;

	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	// Architectural state. pcm_q tracks PC modulo the memory size.
	logic [15:0]   pc_q;
	logic [AW-1:0] pcm_q;
	logic [7:0]    sp_q;
	logic [7:0]    acc_q;
	logic          z_q;
	logic          n_q;
	logic [7:0]    x_q;

	// Sequencer and item latches.
	logic        busy_q;
	upc_t        upc_q;
	logic [15:0] item_addr_q;
	logic [7:0]  item_data_q;
	logic [7:0]  lo_q;
	logic [15:0] tgt_q;

	// Output register.
	logic        out_valid_q;
	logic [7:0]  out_acc_q;
	logic [15:0] out_pc_q;
	logic [7:0]  out_sp_q;
	logic        out_z_q;
	logic        out_n_q;
	logic        out_unk_q;
	logic [2:0]  out_cyc_q;

	ucw_t          cw;
	logic          adv;
	logic          step;
	upc_t          disp_upc;
	logic [7:0]    zp_addr;
	logic [16:0]   stk_full;
	logic [AW-1:0] stk_addr;
	logic [AW-1:0] red_out;
	logic [15:0]   red_in;
	logic [15:0]   ret_addr;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] pcm_inc;
	logic [15:0]   pc_d;
	logic [AW-1:0] pcm_d;
	logic [7:0]    sp_d;
	logic [7:0]    acc_d;
	logic          z_d;
	logic          n_d;

	assign cw = ucode(upc_q);

	// The final step holds while the previous result has not been taken.
	assign adv  = !((cw.seq == SEQ_DONE) && out_valid_q && !result.ready);
	assign step = busy_q && adv;

	assign item.ready = !busy_q && !clearing_q;

	always_comb begin
		case (rdata_q)
			OP_LDA_IMM: disp_upc = UPC_I0;
			OP_LDA_ZP:  disp_upc = UPC_Z0;
			OP_LDA_ZPX: disp_upc = UPC_X0;
			OP_JSR:     disp_upc = UPC_J0;
			default:    disp_upc = UPC_U0;
		endcase
	end

	// Zero-page operand, wrapping within page zero when X is added.
	assign zp_addr = rdata_q + (cw.zp_x ? x_q : 8'd0);

	// Stack address in page one, folded once into a small memory.
	assign stk_full = {8'd0, 1'b1, sp_q};
	assign stk_addr = (stk_full >= SIZE_W) ? AW'(stk_full - SIZE_W) : AW'(stk_full);

	assign ret_addr = pc_q - 16'd1;
	assign red_in   = (cw.red_sel == RED_TARGET) ? {rdata_q, lo_q} : item_addr_q;

	m6502_addr_mod #(
		.MEM_BYTES (MEM_BYTES)
	) u_addr_mod (
		.clk  (clk),
		.load (step && cw.red_start),
		.addr (red_in),
		.rem  (red_out)
	);

	always_comb begin
		case (cw.addr_sel)
			ADDR_PC:    mem_addr = pcm_q;
			ADDR_ZP:    mem_addr = AW'(zp_addr);
			ADDR_STACK: mem_addr = stk_addr;
			ADDR_RED:   mem_addr = red_out;
			default:    mem_addr = pcm_q;
		endcase
		case (cw.wd_sel)
			WD_IN:     mem_wdata = item_data_q;
			WD_RET_HI: mem_wdata = ret_addr[15:8];
			WD_RET_LO: mem_wdata = ret_addr[7:0];
			default:   mem_wdata = item_data_q;
		endcase
		if (clearing_q) begin
			mem_addr  = clr_addr_q;
			mem_wdata = 8'd0;
		end
	end

	assign mem_we = clearing_q || (step && cw.mem_wr);
	assign mem_re = step && cw.mem_rd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// Next architectural values; they also feed the output register.
	assign pcm_inc = ((pc_q == 16'hFFFF) || (pcm_q == LAST_ADDR)) ? '0 : pcm_q + 1'b1;

	always_comb begin
		pc_d  = pc_q;
		pcm_d = pcm_q;
		if (cw.pc_jump) begin
			pc_d  = tgt_q;
			pcm_d = red_out;
		end else if (cw.pc_inc) begin
			pc_d  = pc_q + 16'd1;
			pcm_d = pcm_inc;
		end
		sp_d  = cw.sp_dec ? (sp_q - 8'd1) : sp_q;
		acc_d = cw.ld_acc ? rdata_q : acc_q;
		z_d   = cw.ld_acc ? (rdata_q == 8'd0) : z_q;
		n_d   = cw.ld_acc ? ((rdata_q & SIGN_BIT) != 8'd0) : n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			pc_q        <= PC_RESET;
			pcm_q       <= PCM_RESET;
			sp_q        <= SP_RESET;
			acc_q       <= 8'd0;
			z_q         <= 1'b0;
			n_q         <= 1'b0;
			x_q         <= 8'd0;
			busy_q      <= 1'b0;
			upc_q       <= UPC_E0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					clearing_q <= 1'b0;
				end
			end

			if (cfg_wr_en) begin
				x_q <= cfg_wr_data;
			end

			// A new result loaded at this edge keeps the register full.
			if (result.valid && result.ready && !(step && (cw.seq == SEQ_DONE))) begin
				out_valid_q <= 1'b0;
			end

			if (item.valid && item.ready) begin
				busy_q <= 1'b1;
				upc_q  <= item.action ? UPC_E0 : UPC_W0;
			end

			if (step) begin
				pc_q  <= pc_d;
				pcm_q <= pcm_d;
				sp_q  <= sp_d;
				acc_q <= acc_d;
				z_q   <= z_d;
				n_q   <= n_d;
				case (cw.seq)
					SEQ_NEXT:     upc_q <= cw.next;
					SEQ_DISPATCH: upc_q <= disp_upc;
					SEQ_DONE: begin
						busy_q      <= 1'b0;
						out_valid_q <= 1'b1;
					end
					default:      upc_q <= cw.next;
				endcase
			end
		end
	end

	// Payload registers: item latch, JSR operands and the result.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_addr_q <= item.mem_address;
			item_data_q <= item.mem_data;
		end
		if (step && cw.ld_lo) begin
			lo_q <= rdata_q;
		end
		if (step && cw.red_start) begin
			tgt_q <= {rdata_q, lo_q};
		end
		if (step && (cw.seq == SEQ_DONE)) begin
			out_acc_q <= acc_d;
			out_pc_q  <= pc_d;
			out_sp_q  <= sp_d;
			out_z_q   <= z_d;
			out_n_q   <= n_d;
			out_unk_q <= cw.unknown;
			out_cyc_q <= cw.cycles;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.accumulator     = out_acc_q;
	assign result.program_counter = out_pc_q;
	assign result.stack_pointer   = out_sp_q;
	assign result.zero_flag       = out_z_q;
	assign result.negative_flag   = out_n_q;
	assign result.unknown_opcode  = out_unk_q;
	assign result.cycles_used     = out_cyc_q;

endmodule

// ===== sim/cpu_shadow_check.sv =====
`timescale 1ns / 1ps

// Watches the item, result and config ports of the core, keeps its own copy of
// the memory and registers, and compares every result transaction with the
// oldest outstanding prediction.
module cpu_shadow_check import m6502_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	m6502_item_if       item,
	m6502_result_if     result,
	output int          mismatches,
	output int          awaiting,
	output logic [15:0] model_pc
);

	localparam logic [15:0] STACK_BASE = 16'h0100;

	typedef struct packed {
		logic [7:0]  acc;
		logic [15:0] pc;
		logic [7:0]  sp;
		logic        z;
		logic        n;
		logic        unknown;
		logic [2:0]  cycles;
	} core_report_t;

	logic [7:0]   ram [M6502_MEM_BYTES];
	logic [15:0]  cpu_pc;
	logic [7:0]   cpu_sp;
	logic [7:0]   cpu_a;
	logic         cpu_z;
	logic         cpu_n;
	logic [7:0]   cpu_x;
	core_report_t reports_due[$];

	function automatic logic [7:0] ram_read(input logic [15:0] addr);
		return ram[int'(addr) % M6502_MEM_BYTES];
	endfunction

	function automatic void ram_write(input logic [15:0] addr, input logic [7:0] data);
		ram[int'(addr) % M6502_MEM_BYTES] = data;
	endfunction

	function automatic logic [7:0] fetch_next();
		logic [7:0] b;
		b = ram_read(cpu_pc);
		cpu_pc = cpu_pc + 16'd1;
		return b;
	endfunction

	function automatic void load_a(input logic [7:0] v);
		cpu_a = v;
		cpu_z = (v == 8'h00);
		cpu_n = (v & SIGN_BIT) != 8'h00;
	endfunction

	function automatic void push_byte(input logic [7:0] v);
		ram_write(STACK_BASE + {8'h00, cpu_sp}, v);
		cpu_sp = cpu_sp - 8'd1;
	endfunction

	task automatic report_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		core_report_t due;
		logic [7:0]   op;
		logic [7:0]   zp;
		logic [7:0]   lo;
		logic [7:0]   hi;
		logic [15:0]  ret;
		logic         unk;
		logic [2:0]   cyc;
		if (!arst_n) begin
			foreach (ram[i]) ram[i] = 8'h00;
			cpu_pc = PC_RESET;
			cpu_sp = SP_RESET;
			cpu_a = 8'h00;
			cpu_z = 1'b0;
			cpu_n = 1'b0;
			cpu_x = 8'h00;
			reports_due.delete();
			mismatches = 0;
			awaiting = 0;
			model_pc = PC_RESET;
		end else begin
			// The result side goes first: a result never belongs to an item
			// accepted at the same edge.
			if (result.valid && result.ready) begin
				if (reports_due.size() == 0) begin
					$error("result transaction with nothing outstanding");
					mismatches++;
				end else begin
					due = reports_due.pop_front();
					report_field("accumulator", due.acc, result.accumulator);
					report_field("program_counter", due.pc, result.program_counter);
					report_field("stack_pointer", due.sp, result.stack_pointer);
					report_field("zero_flag", due.z, result.zero_flag);
					report_field("negative_flag", due.n, result.negative_flag);
					report_field("unknown_opcode", due.unknown, result.unknown_opcode);
					report_field("cycles_used", due.cycles, result.cycles_used);
				end
			end
			if (item.valid && item.ready) begin
				unk = 1'b0;
				cyc = CYC_WRITE;
				if (!item.action) begin
					ram_write(item.mem_address, item.mem_data);
				end else begin
					op = fetch_next();
					case (op)
						OP_LDA_IMM: begin
							load_a(fetch_next());
							cyc = CYC_LDA_IMM;
						end
						OP_LDA_ZP: begin
							zp = fetch_next();
							load_a(ram_read({8'h00, zp}));
							cyc = CYC_LDA_ZP;
						end
						OP_LDA_ZPX: begin
							// The index wraps inside page zero.
							zp = fetch_next() + cpu_x;
							load_a(ram_read({8'h00, zp}));
							cyc = CYC_LDA_ZPX;
						end
						OP_JSR: begin
							lo = fetch_next();
							hi = fetch_next();
							ret = cpu_pc - 16'd1;
							push_byte(ret[15:8]);
							push_byte(ret[7:0]);
							cpu_pc = {hi, lo};
							cyc = CYC_JSR;
						end
						default: begin
							unk = 1'b1;
							cyc = CYC_UNKNOWN;
						end
					endcase
				end
				due.acc = cpu_a;
				due.pc = cpu_pc;
				due.sp = cpu_sp;
				due.z = cpu_z;
				due.n = cpu_n;
				due.unknown = unk;
				due.cycles = cyc;
				reports_due.push_back(due);
			end
			if (cfg_wr_en) cpu_x = cfg_wr_data;
			awaiting = reports_due.size();
			model_pc = cpu_pc;
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the small 6502-style core. Predictions and
// comparisons live in the shadow checker instantiated beside the core; this
// module only drives the ports, paces both channels and decides the outcome.
module tb_top;
	import m6502_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 5;
	// The core clears 64 KiB after reset, then each item takes its microprogram
	// steps plus sender gaps and receiver stalls. The limit leaves a wide
	// margin over the slowest correct run.
	localparam int unsigned RUN_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS  = 275;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 16;

	// Item kinds on the action field.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EXEC  = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'h00;

	m6502_item_if   item_ch ();
	m6502_result_if result_ch ();

	int          mismatches;
	int          awaiting;
	logic [15:0] model_pc;

	// Stimulus bookkeeping: where the next planted instruction goes, how many
	// item transactions were accepted, and the state of the sender's burst.
	logic [15:0] code_pc;
	int          items_sent = 0;
	int          burst_left = 0;
	bit          hold_wanted = 1'b0;

	int unsigned cycle_count = 0;

	always #(CLK_HALF) clk = ~clk;

	mini_6502_load_jsr_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item(item_ch),
		.result(result_ch)
	);

	cpu_shadow_check shadow (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item(item_ch),
		.result(result_ch),
		.mismatches(mismatches),
		.awaiting(awaiting),
		.model_pc(model_pc)
	);

	// A hung handshake ends the run here rather than at the simulator's limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result receiver. It runs through segments of random length, each with
	// its own stall density, from always ready to mostly stalled. Once, when
	// the stimulus asks for it, it holds off for a long stretch so that the
	// output register fills, the core waits in its final step and the item
	// channel backs up while the sender keeps offering.
	int seg_left = 0;
	int seg_kind = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (hold_wanted && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			result_ch.ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_kind = $urandom_range(0, 3);
				seg_left = $urandom_range(10, 80);
			end
			seg_left--;
			case (seg_kind)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= $urandom_range(0, 1);
				2: result_ch.ready <= ($urandom_range(0, 3) == 0);
				default: result_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Offers one item transaction and returns at the falling edge after it was
	// accepted. Valid stays high, so back-to-back items need no dead cycle;
	// between bursts the sender drops valid for a random gap, sometimes none.
	task automatic send_item(input logic act, input logic [15:0] addr,
			input logic [7:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				item_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		item_ch.action = act;
		item_ch.mem_address = addr;
		item_ch.mem_data = data;
		item_ch.valid = 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Drops valid and waits until every accepted item has had its result.
	// Every item produces a result, so the core is idle at that point.
	task automatic wait_idle();
		item_ch.valid = 1'b0;
		while (awaiting != 0) @(negedge clk);
	endtask

	// Random noise may have executed whatever happened to be in memory, so
	// the code pointer is taken from the predicted PC once the core is idle.
	task automatic sync_pc();
		wait_idle();
		code_pc = model_pc;
	endtask

	// X may only change while the core is idle.
	task automatic set_index_x(input logic [7:0] v);
		wait_idle();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Writes one instruction at the code pointer, byte by byte, then executes
	// it. The code pointer follows the instruction: past its bytes, or to the
	// JSR target.
	task automatic plant(input logic [7:0] op, input logic [7:0] b1,
			input logic [7:0] b2);
		int len;
		if (op == OP_JSR)
			len = 3;
		else if (op == OP_LDA_IMM || op == OP_LDA_ZP || op == OP_LDA_ZPX)
			len = 2;
		else
			len = 1;
		send_item(ACT_WRITE, code_pc, op);
		if (len > 1) send_item(ACT_WRITE, code_pc + 16'd1, b1);
		if (len > 2) send_item(ACT_WRITE, code_pc + 16'd2, b2);
		// The address and data of an execute item are ignored; they are
		// randomized anyway.
		send_item(ACT_EXEC, 16'($urandom()), 8'($urandom()));
		code_pc = (op == OP_JSR) ? {b2, b1} : code_pc + 16'(len);
	endtask

	// Byte values biased toward the ones that move Z, N and the wraps.
	function automatic logic [7:0] edgy_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'h80;
			2: return 8'hFF;
			3: return 8'h7F;
			default: return 8'($urandom());
		endcase
	endfunction

	// A well-formed program: a few instructions planted one after the other,
	// mixed with data written into page zero for the loads to pick up.
	task automatic run_program();
		int         count;
		int         pick;
		logic [7:0] op;
		logic [7:0] b1;
		logic [7:0] b2;
		sync_pc();
		count = $urandom_range(1, 8);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			b1 = edgy_byte();
			b2 = edgy_byte();
			if (pick < 15) begin
				send_item(ACT_WRITE, {8'h00, 8'($urandom())}, b2);
			end else if (pick < 37) begin
				plant(OP_LDA_IMM, b1, b2);
			end else if (pick < 56) begin
				plant(OP_LDA_ZP, b1, b2);
			end else if (pick < 75) begin
				plant(OP_LDA_ZPX, b1, b2);
			end else if (pick < 90) begin
				// JSR targets lean toward the top of memory, the stack page
				// and page zero so that PC and stack wraps come up often.
				b1 = 8'($urandom());
				case ($urandom_range(0, 4))
					0: b2 = 8'hFF;
					1: b2 = 8'h01;
					2: b2 = 8'h00;
					default: b2 = 8'($urandom());
				endcase
				plant(OP_JSR, b1, b2);
			end else begin
				do op = 8'($urandom());
				while (op == OP_LDA_IMM || op == OP_LDA_ZP || op == OP_LDA_ZPX ||
					op == OP_JSR);
				plant(op, b1, b2);
			end
		end
	endtask

	// Noise: random writes anywhere, mostly near the interesting pages, and
	// executes of whatever memory holds at the moment.
	task automatic noise_burst(input int count);
		logic [15:0] addr;
		repeat (count) begin
			case ($urandom_range(0, 3))
				0: addr = {8'h00, 8'($urandom())};
				1: addr = {8'h01, 8'($urandom())};
				2: addr = {8'hFF, 8'($urandom())};
				default: addr = 16'($urandom());
			endcase
			send_item(logic'($urandom_range(0, 1)), addr, 8'($urandom()));
		end
	endtask

	task automatic random_phase(input int goal);
		while (items_sent < goal) begin
			if ($urandom_range(0, 4) == 0)
				noise_burst($urandom_range(4, 30));
			else
				run_program();
		end
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.action = ACT_WRITE;
		item_ch.mem_address = 16'h0000;
		item_ch.mem_data = 8'h00;
		result_ch.ready = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed part with X at its reset value. The first execute runs on
		// the cleared memory at the reset vector and so hits an unknown opcode.
		send_item(ACT_EXEC, 16'hFFFF, 8'hFF);
		sync_pc();
		plant(OP_LDA_IMM, 8'h00, 8'h00);  // zero result sets Z
		plant(OP_LDA_IMM, 8'h80, 8'h00);  // operand byte sits past the PC wrap
		plant(OP_LDA_IMM, 8'hFF, 8'h00);  // N set
		send_item(ACT_WRITE, 16'h00FF, 8'h7F);
		plant(OP_LDA_ZP, 8'hFF, 8'h00);   // top of page zero, Z and N clear
		plant(OP_JSR, 8'hFF, 8'hFF);      // jump to the last byte of memory
		plant(8'hFF, 8'h00, 8'h00);       // unknown opcode, PC wraps to zero
		plant(OP_LDA_ZPX, 8'h00, 8'h00);  // X zero, reads the byte at 0x0000

		// Each X setting gets its own phase; 0xFF comes first and zero last, and
		// the long receiver hold-off is set off at the start of the second one.
		set_index_x(8'hFF);
		sync_pc();
		plant(OP_LDA_ZPX, 8'h01, 8'h00);  // 0x01 + 0xFF wraps to 0x00
		plant(OP_LDA_ZPX, 8'hFF, 8'h00);  // 0xFF + 0xFF wraps to 0xFE
		random_phase(items_sent + PHASE_ITEMS);

		set_index_x(8'h80);
		hold_wanted = 1'b1;
		noise_burst(30);
		random_phase(items_sent + PHASE_ITEMS);

		set_index_x(8'h01);
		random_phase(items_sent + PHASE_ITEMS);

		set_index_x(8'($urandom_range(2, 254)));
		random_phase(items_sent + PHASE_ITEMS);

		set_index_x(8'h00);
		random_phase(items_sent + PHASE_ITEMS);

		// Everything was accepted; let the last results drain, then a few
		// more cycles for anything unexpected to show up.
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && awaiting == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
